// ----- rtl/core/bltsa_pkg.sv -----
// Shared types and constants for the block-linear texture address generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bltsa_pkg;

	localparam int COORD_W      = 14;
	localparam int SLICE_W      = 11;
	localparam int OFFSET_W     = 32;
	localparam int BPP_W        = 5;
	localparam int DIM_W        = 15;
	localparam int LOG2_W       = 3;
	localparam int ALIGN_W      = 5;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 4;
	localparam int IN_FIELDS_W  = 2 * COORD_W + SLICE_W;
	localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_W        = 2 * OFFSET_W;
	localparam int USER_W       = 8;
	localparam int GOB_X_LOG2     = 6;
	localparam int GOB_Y_LOG2     = 3;
	localparam int GOB_BYTES_LOG2 = 9;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BPP       = 4'd0,
		REG_WIDTH     = 4'd1,
		REG_HEIGHT    = 4'd2,
		REG_BH_LOG2   = 4'd3,
		REG_BD_LOG2   = 4'd4,
		REG_ALIGN     = 4'd5,
		REG_SRC_SIZE  = 4'd6,
		REG_LIN_SRC   = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [BPP_W-1:0]    bpp;
		logic [DIM_W-1:0]    height;
		logic [LOG2_W-1:0]   bh_log2;
		logic [LOG2_W-1:0]   bd_log2;
		logic [OFFSET_W-1:0] src_size;
		logic                lin_src;
		logic                bpp_ok;
		logic [OFFSET_W-1:0] pitch;
		logic [OFFSET_W-1:0] pitch_h;
		logic [OFFSET_W-1:0] blk_bytes;
		logic [OFFSET_W-1:0] slc_bytes;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] line;
		logic [SLICE_W-1:0] slice;
		logic               new_line;
		logic               fmt_err;
	} item_t;

endpackage

// ----- rtl/core/bltsa_cfg.sv -----
// Configuration registers and the derive sequencer (pitch, block and slice sizes).
// Depends on bltsa_pkg.
`timescale 1ns / 1ps
module bltsa_cfg
	import bltsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic                  busy
);

	typedef enum logic [1:0] {D_IDLE, D_STRIDE, D_BLOCK, D_SLICE} dstate_t;

	dstate_t              state_q;
	logic [BPP_W-1:0]     bpp_q;
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [LOG2_W-1:0]    bh_q;
	logic [LOG2_W-1:0]    bd_q;
	logic [ALIGN_W-1:0]   align_q;
	logic [OFFSET_W-1:0]  src_size_q;
	logic                 lin_src_q;
	logic [OFFSET_W-1:0]  pitch_q;
	logic [OFFSET_W-1:0]  pitch_h_q;
	logic [OFFSET_W-1:0]  block_q;
	logic [OFFSET_W-1:0]  slice_q;
	logic [37:0]          stride_q;
	logic [15:0]          ceil_h_q;

	logic [32:0] align_mask;
	logic [32:0] aligned_w;
	logic [37:0] stride_d;
	logic [19:0] pitch_d;
	logic [32:0] gobs_x;
	logic [4:0]  block_sh;
	logic [63:0] block_wide;
	logic [3:0]  h_sh;
	logic [15:0] ceil_h_d;
	logic [46:0] pitch_h_wide;
	logic [47:0] slice_wide;
	logic        wr;

	assign wr        = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == D_IDLE);
	assign busy      = (state_q != D_IDLE);

	assign align_mask   = (33'd1 << align_q) - 33'd1;
	assign aligned_w    = (33'(width_q) + align_mask) & ~align_mask;
	assign stride_d     = 38'(aligned_w) * 38'(bpp_q);
	assign pitch_d      = 20'(width_q) * 20'(bpp_q);
	assign gobs_x       = 33'((stride_q + 38'd63) >> GOB_X_LOG2);
	assign block_sh     = 5'(GOB_BYTES_LOG2) + 5'(bh_q) + 5'(bd_q);
	assign block_wide   = 64'(gobs_x) << block_sh;
	assign h_sh         = 4'(bh_q) + 4'(GOB_Y_LOG2);
	assign ceil_h_d     = (16'(height_q) + (16'd1 << h_sh) - 16'd1) >> h_sh;
	assign pitch_h_wide = 47'(pitch_q) * 47'(height_q);
	assign slice_wide   = 48'(ceil_h_q) * 48'(block_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= D_STRIDE;
			bpp_q       <= BPP_W'(4);
			width_q     <= DIM_W'(1);
			height_q    <= DIM_W'(1);
			bh_q        <= '0;
			bd_q        <= '0;
			align_q     <= '0;
			src_size_q  <= '0;
			lin_src_q   <= 1'b0;
			stride_q    <= '0;
			pitch_q     <= '0;
			pitch_h_q   <= '0;
			block_q     <= '0;
			ceil_h_q    <= '0;
			slice_q     <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (wr) begin
						state_q <= (cfg_index <= REG_LIN_SRC) ? D_STRIDE : D_IDLE;
						unique case (cfg_reg_t'(cfg_index))
							REG_BPP:      bpp_q      <= cfg_data[BPP_W-1:0];
							REG_WIDTH:    width_q    <= cfg_data[DIM_W-1:0];
							REG_HEIGHT:   height_q   <= cfg_data[DIM_W-1:0];
							REG_BH_LOG2:  bh_q       <= cfg_data[LOG2_W-1:0];
							REG_BD_LOG2:  bd_q       <= cfg_data[LOG2_W-1:0];
							REG_ALIGN:    align_q    <= cfg_data[ALIGN_W-1:0];
							REG_SRC_SIZE: src_size_q <= cfg_data[OFFSET_W-1:0];
							REG_LIN_SRC:  lin_src_q  <= cfg_data[0];
							default: ;
						endcase
					end
				end
				D_STRIDE: begin
					state_q  <= D_BLOCK;
					stride_q <= stride_d;
					pitch_q  <= 32'(pitch_d);
				end
				D_BLOCK: begin
					state_q   <= D_SLICE;
					block_q   <= block_wide[OFFSET_W-1:0];
					ceil_h_q  <= ceil_h_d;
					pitch_h_q <= pitch_h_wide[OFFSET_W-1:0];
				end
				D_SLICE: begin
					state_q <= D_IDLE;
					slice_q <= slice_wide[OFFSET_W-1:0];
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_comb begin
		cfg.bpp        = bpp_q;
		cfg.height     = height_q;
		cfg.bh_log2    = bh_q;
		cfg.bd_log2    = bd_q;
		cfg.src_size   = src_size_q;
		cfg.lin_src    = lin_src_q;
		cfg.bpp_ok     = (bpp_q == 5'd1) || (bpp_q == 5'd2) || (bpp_q == 5'd3) ||
		                 (bpp_q == 5'd4) || (bpp_q == 5'd6) || (bpp_q == 5'd8) ||
		                 (bpp_q == 5'd12) || (bpp_q == 5'd16);
		cfg.pitch      = pitch_q;
		cfg.pitch_h    = pitch_h_q;
		cfg.blk_bytes  = block_q;
		cfg.slc_bytes  = slice_q;
	end

endmodule

// ----- rtl/core/bltsa_front.sv -----
// Front end: accepts coordinate transactions, flags new lines and bad texel size.
// Depends on bltsa_pkg.
`timescale 1ns / 1ps
module bltsa_front
	import bltsa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            cfg_busy,
	input  logic            cfg_bpp_ok,
	input  logic            queue_full,
	output logic            push,
	output item_t           push_item
);

	logic [COORD_W-1:0] prev_line_q;
	logic [SLICE_W-1:0] prev_slice_q;
	logic [COORD_W-1:0] line_in;
	logic [SLICE_W-1:0] slice_in;

	assign line_in  = s_tdata[2*COORD_W-1:COORD_W];
	assign slice_in = s_tdata[IN_FIELDS_W-1:2*COORD_W];
	assign s_tready = !cfg_busy && !queue_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_item.column   = s_tdata[COORD_W-1:0];
		push_item.line     = line_in;
		push_item.slice    = slice_in;
		push_item.new_line = (line_in != prev_line_q) || (slice_in != prev_slice_q);
		push_item.fmt_err  = !cfg_bpp_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_line_q  <= '0;
			prev_slice_q <= '0;
		end else if (push) begin
			prev_line_q  <= line_in;
			prev_slice_q <= slice_in;
		end
	end

endmodule

// ----- rtl/core/bltsa_queue.sv -----
// Small queue of classified items between front and back end.
// Depends on bltsa_pkg.
`timescale 1ns / 1ps
module bltsa_queue
	import bltsa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0] wr_ptr_q;
	logic [QUEUE_AW:0] rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
	               (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);
	assign head  = mem_q[rd_ptr_q[QUEUE_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= push_item;
	end

endmodule

// ----- rtl/core/bltsa_back.sv -----
// Back end: three-stage address pipeline (products, sums, bound check and output).
// Depends on bltsa_pkg.
`timescale 1ns / 1ps
module bltsa_back
	import bltsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  item_t             head,
	input  logic              empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	output logic [USER_W-1:0] m_tuser
);

	logic adv;

	logic                valid_s1;
	logic [18:0]         x_s1;
	logic [OFFSET_W-1:0] zlin_s1;
	logic [OFFSET_W-1:0] ylin_s1;
	logic [OFFSET_W-1:0] zt_s1;
	logic [OFFSET_W-1:0] yt_s1;
	logic [COORD_W-1:0]  line_s1;
	logic [SLICE_W-1:0]  slice_s1;
	logic                new_line_s1;
	logic                fmt_err_s1;

	logic                valid_s2;
	logic [OFFSET_W-1:0] src_s2;
	logic [OFFSET_W-1:0] dst_s2;
	logic                new_line_s2;
	logic                fmt_err_s2;

	logic                aborted_q;
	logic [OFFSET_W-1:0] src_s3;
	logic [OFFSET_W-1:0] dst_s3;
	logic                copy_s3;
	logic                fmt_err_s3;

	logic [42:0]          zlin_p;
	logic [45:0]          ylin_p;
	logic [42:0]          zt_p;
	logic [42:0]          yt_p;
	logic [COORD_W-4:0]   by_in;

	logic [SLICE_W-1:0]   bd_mask;
	logic [COORD_W-4:0]   bh_mask;
	logic [COORD_W-4:0]   by_s1;
	logic [4:0]           z_sh;
	logic [4:0]           x_sh;
	logic [OFFSET_W-1:0]  oz;
	logic [OFFSET_W-1:0]  oy;
	logic [63:0]          ox_wide;
	logic [8:0]           entry;
	logic [OFFSET_W-1:0]  tiled;
	logic [OFFSET_W-1:0]  lin;
	logic                 aborted_d;

	assign adv = !m_tvalid || m_tready;
	assign pop = adv && !empty;

	// stage 1 products
	assign by_in  = head.line[COORD_W-1:GOB_Y_LOG2];
	assign zlin_p = 43'(head.slice) * 43'(cfg.pitch_h);
	assign ylin_p = 46'(head.line) * 46'(cfg.pitch);
	assign zt_p   = 43'(head.slice >> cfg.bd_log2) * 43'(cfg.slc_bytes);
	assign yt_p   = 43'(by_in >> cfg.bh_log2) * 43'(cfg.blk_bytes);

	// stage 2 sums
	assign bd_mask = (SLICE_W'(1) << cfg.bd_log2) - SLICE_W'(1);
	assign bh_mask = ((COORD_W-3)'(1) << cfg.bh_log2) - (COORD_W-3)'(1);
	assign by_s1   = line_s1[COORD_W-1:GOB_Y_LOG2];
	assign z_sh    = 5'(GOB_BYTES_LOG2) + 5'(cfg.bh_log2);
	assign x_sh    = z_sh + 5'(cfg.bd_log2);
	assign oz      = zt_s1 + (OFFSET_W'(slice_s1 & bd_mask) << z_sh);
	assign oy      = yt_s1 + (OFFSET_W'(by_s1 & bh_mask) << GOB_BYTES_LOG2);
	assign ox_wide = 64'(x_s1 >> GOB_X_LOG2) << x_sh;
	assign entry   = {x_s1[5], line_s1[2:1], x_s1[4], line_s1[0], x_s1[3:0]};
	assign tiled   = (oz + oy + ox_wide[OFFSET_W-1:0]) | OFFSET_W'(entry);
	assign lin     = zlin_s1 + ylin_s1 + OFFSET_W'(x_s1);

	// stage 3 bound check
	always_comb begin
		aborted_d = new_line_s2 ? 1'b0 : aborted_q;
		if (!fmt_err_s2 && !aborted_d && (src_s2 >= cfg.src_size)) aborted_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_tvalid  <= 1'b0;
			aborted_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !empty;
			valid_s2 <= valid_s1;
			m_tvalid <= valid_s2;
			if (valid_s2) aborted_q <= aborted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1        <= 19'(head.column) * 19'(cfg.bpp);
			zlin_s1     <= zlin_p[OFFSET_W-1:0];
			ylin_s1     <= ylin_p[OFFSET_W-1:0];
			zt_s1       <= zt_p[OFFSET_W-1:0];
			yt_s1       <= yt_p[OFFSET_W-1:0];
			line_s1     <= head.line;
			slice_s1    <= head.slice;
			new_line_s1 <= head.new_line;
			fmt_err_s1  <= head.fmt_err;

			src_s2      <= cfg.lin_src ? lin : tiled;
			dst_s2      <= cfg.lin_src ? tiled : lin;
			new_line_s2 <= new_line_s1;
			fmt_err_s2  <= fmt_err_s1;

			src_s3      <= fmt_err_s2 ? '0 : src_s2;
			dst_s3      <= fmt_err_s2 ? '0 : dst_s2;
			copy_s3     <= !fmt_err_s2 && !aborted_d;
			fmt_err_s3  <= fmt_err_s2;
		end
	end

	assign m_tdata = {dst_s3, src_s3};
	assign m_tuser = {6'b0, fmt_err_s3, copy_s3};

endmodule

// ----- rtl/core/block_linear_texture_swizzle_address.sv -----
// Block-linear texture address generator: one address pair per texel.
// Throughput one transaction per cycle while neither m_tready nor cfg_busy holds it off.
// Queue of four items lets the front keep accepting while the output stalls.
// After reset and after each write to registers 0 to 7, states D_STRIDE, D_BLOCK and D_SLICE recompute
// pitch, block and slice sizes; no input or config transaction is taken during them.
// Reset is asynchronous, active low; clears line tracking and restores register defaults.
`timescale 1ns / 1ps
module block_linear_texture_swizzle_address
	import bltsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // column, line, slice
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // source_offset, dest_offset
	output logic [USER_W-1:0]     m_tuser,   // copy_enable, format_error
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	logic  cfg_busy;
	logic  push;
	item_t push_item;
	logic  pop;
	item_t head;
	logic  empty;
	logic  full;

	bltsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (cfg_busy)
	);

	bltsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_busy   (cfg_busy),
		.cfg_bpp_ok (cfg.bpp_ok),
		.queue_full (full),
		.push       (push),
		.push_item  (push_item)
	);

	bltsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	bltsa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- verif/block_linear_texture_swizzle_address_tb.sv -----
// Self-checking testbench for block_linear_texture_swizzle_address: drives texel coordinates
// and register writes, predicts tiled/linear offset pairs and compares every result transaction.
// Depends on bltsa_pkg and the block's RTL only.
`timescale 1ns / 1ps
module block_linear_texture_swizzle_address_tb
	import bltsa_pkg::*;
();

	localparam int LIMIT_CYCLES = 500000;
	localparam int LONG_HOLD = 80;
	localparam int NUM_PHASES = 12;
	localparam int TEXELS_PER_PHASE = 52;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] line;
		logic [SLICE_W-1:0] slice;
	} texel_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] src;
		logic [OFFSET_W-1:0] dst;
		logic                copy_en;
		logic                fmt_err;
	} result_t;

	typedef enum logic {ROW_TEXEL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		texel_t                 tex;
		logic                   typed;
		result_t                want;
	} row_t;

	localparam result_t ORIGIN_RESULT = '{src: 0, dst: 0, copy_en: 1'b0, fmt_err: 1'b0};
	localparam result_t FMT_ERR_RESULT = '{src: 0, dst: 0, copy_en: 1'b0, fmt_err: 1'b1};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic [USER_W-1:0]     m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	block_linear_texture_swizzle_address DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow registers and derived layout
	logic [BPP_W-1:0]    shd_bpp;
	logic [DIM_W-1:0]    shd_width;
	logic [DIM_W-1:0]    shd_height;
	logic [LOG2_W-1:0]   shd_bh;
	logic [LOG2_W-1:0]   shd_bd;
	logic [ALIGN_W-1:0]  shd_align;
	logic [OFFSET_W-1:0] shd_src_size;
	logic                shd_lin_src;
	logic [OFFSET_W-1:0] lay_pitch;
	logic [OFFSET_W-1:0] lay_blk_bytes;
	logic [OFFSET_W-1:0] lay_slc_bytes;
	// line tracking
	logic                trk_aborted;
	logic [COORD_W-1:0]  trk_line;
	logic [SLICE_W-1:0]  trk_slice;

	result_t expected_offsets[$];
	row_t    directed_rows[$];
	int      bpp_list[8] = '{1, 2, 3, 4, 6, 8, 12, 16};

	int  cycle_count = 0;
	int  mismatches = 0;
	int  texels_sent = 0;
	int  results_checked = 0;
	int  skipped_seen = 0;
	int  fmt_err_seen = 0;
	int  reg_writes = 0;
	bit  sender_idles = 1'b1;
	bit  receiver_idles = 1'b1;
	bit  stall_hold = 1'b0;

	always #5 clk = ~clk;

	function automatic logic [63:0] ceil_shift(input logic [63:0] v, input int unsigned s);
		return (v + (64'd1 << s) - 64'd1) >> s;
	endfunction

	function automatic void recompute_layout();
		logic [63:0] aligned_w;
		logic [63:0] stride;
		logic [63:0] gobs_x;
		aligned_w = ceil_shift(64'(shd_width), shd_align) << shd_align;
		stride = aligned_w * 64'(shd_bpp);
		gobs_x = ceil_shift(stride, GOB_X_LOG2);
		lay_pitch = 32'(64'(shd_width) * 64'(shd_bpp));
		lay_blk_bytes = 32'(gobs_x << (GOB_BYTES_LOG2 + shd_bh + shd_bd));
		lay_slc_bytes = 32'(ceil_shift(64'(shd_height), GOB_Y_LOG2 + shd_bh)
			* 64'(lay_blk_bytes));
	endfunction

	function automatic void reset_shadow();
		shd_bpp = 5'd4;
		shd_width = 15'd1;
		shd_height = 15'd1;
		shd_bh = '0;
		shd_bd = '0;
		shd_align = '0;
		shd_src_size = '0;
		shd_lin_src = 1'b0;
		trk_aborted = 1'b0;
		trk_line = '0;
		trk_slice = '0;
		recompute_layout();
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BPP:       shd_bpp = data[BPP_W-1:0];
			REG_WIDTH:     shd_width = data[DIM_W-1:0];
			REG_HEIGHT:    shd_height = data[DIM_W-1:0];
			REG_BH_LOG2:   shd_bh = data[LOG2_W-1:0];
			REG_BD_LOG2:   shd_bd = data[LOG2_W-1:0];
			REG_ALIGN:     shd_align = data[ALIGN_W-1:0];
			REG_SRC_SIZE:  shd_src_size = data[OFFSET_W-1:0];
			REG_LIN_SRC:   shd_lin_src = data[0];
			default: return;
		endcase
		recompute_layout();
	endfunction

	function automatic bit bpp_supported(input logic [BPP_W-1:0] b);
		case (b)
			5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic result_t predict_offsets(input texel_t t);
		result_t     r;
		logic [63:0] x, y, z, by, oz, oy, ox, entry, tiled, lin;
		if (t.line != trk_line || t.slice != trk_slice)
			trk_aborted = 1'b0;
		trk_line = t.line;
		trk_slice = t.slice;
		if (!bpp_supported(shd_bpp))
			return FMT_ERR_RESULT;
		y = 64'(t.line);
		z = 64'(t.slice);
		x = 64'(t.column) * 64'(shd_bpp);
		oz = (z >> shd_bd) * 64'(lay_slc_bytes)
			+ ((z & ((64'd1 << shd_bd) - 64'd1)) << (GOB_BYTES_LOG2 + shd_bh));
		by = y >> GOB_Y_LOG2;
		oy = (by >> shd_bh) * 64'(lay_blk_bytes)
			+ ((by & ((64'd1 << shd_bh) - 64'd1)) << GOB_BYTES_LOG2);
		ox = (x >> GOB_X_LOG2) << (GOB_BYTES_LOG2 + shd_bh + shd_bd);
		entry = ((x & 64'd32) << 3) | ((x & 64'd16) << 1) | (x & 64'd15)
			| ((y & 64'd6) << 5) | ((y & 64'd1) << 4);
		tiled = (oz + oy + ox) | entry;
		lin = z * 64'(lay_pitch) * 64'(shd_height) + y * 64'(lay_pitch) + x;
		r.src = shd_lin_src ? lin[31:0] : tiled[31:0];
		r.dst = shd_lin_src ? tiled[31:0] : lin[31:0];
		if (!trk_aborted && r.src >= shd_src_size)
			trk_aborted = 1'b1;
		r.copy_en = !trk_aborted;
		r.fmt_err = 1'b0;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_texel(input texel_t t, input logic typed, input result_t want);
		int      gap;
		result_t r;
		gap = pick_gap(sender_idles);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-IN_FIELDS_W){1'b0}}, t.slice, t.line, t.column};
		do @(posedge clk); while (!s_tready);
		r = predict_offsets(t);
		expected_offsets.push_back(typed ? want : r);
		texels_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		reg_writes++;
		@(negedge clk);
	endtask

	// stop offering texels and let the pipeline run dry
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (expected_offsets.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.data = data;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_texel_row(input int c, input int l, input int s,
			input logic typed = 1'b0, input result_t want = '0);
		row_t row;
		row = '0;
		row.kind = ROW_TEXEL;
		row.tex = '{column: c[COORD_W-1:0], line: l[COORD_W-1:0], slice: s[SLICE_W-1:0]};
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic texel_t run_texel(input int c, input int l, input int s);
		return '{column: c[COORD_W-1:0], line: l[COORD_W-1:0], slice: s[SLICE_W-1:0]};
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ERROR %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_offsets.size() == 0) begin
				mismatches++;
				$display("%0t ERROR unexpected transaction: expected none, actual %h user %h",
					$time, m_tdata, m_tuser);
			end else begin
				want = expected_offsets.pop_front();
				check_field("source_offset", want.src, m_tdata[OFFSET_W-1:0]);
				check_field("dest_offset", want.dst, m_tdata[2*OFFSET_W-1:OFFSET_W]);
				check_field("copy_enable", 32'(want.copy_en), 32'(m_tuser[0]));
				check_field("format_error", 32'(want.fmt_err), 32'(m_tuser[1]));
				check_field("tuser padding", 32'd0, 32'(m_tuser[USER_W-1:2]));
				results_checked++;
				if (!want.copy_en)
					skipped_seen++;
				if (want.fmt_err)
					fmt_err_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, expected_offsets.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin : drive_ready
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				stall_hold = 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap(receiver_idles);
			end
		end
	end

	initial begin : stimulus
		bit                    in_cfg;
		bit                    paused;
		bit                    held;
		int                    phase;
		int                    sent_in_phase;
		int                    lim_w, lim_h;
		int                    col, ln, sl, len;
		logic [CFG_DATA_W-1:0] reg_val [8];
		logic [CFG_DATA_W-1:0] noise;
		int                    w;
		in_cfg = 1'b0;
		paused = 1'b0;
		held = 1'b0;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_shadow();

		// directed: reset defaults, extremes, direction, bound skip, bad texel sizes
		add_texel_row(0, 0, 0, 1'b1, ORIGIN_RESULT);
		add_texel_row(16383, 16383, 2047);
		add_reg_row(REG_SRC_SIZE, 32'hFFFF_FFFF);
		add_reg_row(REG_WIDTH, 64);
		add_reg_row(REG_HEIGHT, 16);
		add_reg_row(REG_BPP, 4);
		add_reg_row(REG_BH_LOG2, 1);
		add_reg_row(REG_BD_LOG2, 1);
		add_reg_row(REG_ALIGN, 4);
		add_reg_row(REG_LIN_SRC, 0);
		add_texel_row(0, 0, 0);
		add_texel_row(5, 3, 0);
		add_texel_row(63, 7, 1);
		add_texel_row(16383, 0, 0);
		add_texel_row(0, 16383, 0);
		add_texel_row(0, 0, 2047);
		add_texel_row(16383, 16383, 2047);
		add_reg_row(REG_LIN_SRC, 1);
		add_texel_row(1, 1, 1);
		add_texel_row(10, 2, 0);
		add_reg_row(REG_SRC_SIZE, 100);
		add_texel_row(0, 5, 0);
		add_texel_row(0, 0, 0);
		add_texel_row(30, 0, 0);
		add_texel_row(1, 0, 0);
		add_texel_row(1, 1, 0);
		add_reg_row(REG_BPP, 0);
		add_texel_row(3, 4, 0, 1'b1, FMT_ERR_RESULT);
		add_reg_row(REG_BPP, 31);
		add_texel_row(3, 4, 0, 1'b1, FMT_ERR_RESULT);
		add_reg_row(REG_BPP, 5);
		add_texel_row(7, 4, 0, 1'b1, FMT_ERR_RESULT);
		add_reg_row(REG_BPP, 16);
		add_reg_row(REG_WIDTH, 0);
		add_reg_row(REG_HEIGHT, 0);
		add_reg_row(REG_ALIGN, 31);
		add_reg_row(REG_BH_LOG2, 7);
		add_reg_row(REG_BD_LOG2, 7);
		add_reg_row(REG_SRC_SIZE, 32'hFFFF_FFFF);
		add_reg_row(REG_SPARE_FIRST + 4'd7, 32'hFFFF_FFFF);
		add_texel_row(100, 100, 100);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				if (!in_cfg) begin
					settle();
					in_cfg = 1'b1;
				end
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				if (in_cfg) begin
					cfg_valid <= 1'b0;
					in_cfg = 1'b0;
				end
				send_texel(directed_rows[i].tex, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			sender_idles = (phase == 2 || phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
			receiver_idles = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (phase == 0) begin
				reg_val[REG_BPP] = 16;
				reg_val[REG_WIDTH] = 16384;
				reg_val[REG_HEIGHT] = 16384;
				reg_val[REG_BH_LOG2] = 5;
				reg_val[REG_BD_LOG2] = 5;
				reg_val[REG_ALIGN] = 16;
				reg_val[REG_SRC_SIZE] = 32'hFFFF_FFFF;
				reg_val[REG_LIN_SRC] = $urandom_range(0, 1);
			end else if (phase == 1) begin
				reg_val[REG_BPP] = 1;
				reg_val[REG_WIDTH] = 1;
				reg_val[REG_HEIGHT] = 1;
				reg_val[REG_BH_LOG2] = 0;
				reg_val[REG_BD_LOG2] = 0;
				reg_val[REG_ALIGN] = 0;
				reg_val[REG_SRC_SIZE] = 0;
				reg_val[REG_LIN_SRC] = $urandom_range(0, 1);
			end else begin
				reg_val[REG_BPP] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
					: bpp_list[$urandom_range(0, 7)];
				reg_val[REG_WIDTH] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 32767)
					: ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16384)
					: $urandom_range(1, 96);
				reg_val[REG_HEIGHT] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 32767)
					: $urandom_range(1, 64);
				reg_val[REG_BH_LOG2] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, 5);
				reg_val[REG_BD_LOG2] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, 5);
				reg_val[REG_ALIGN] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
					: $urandom_range(0, 16);
				case ($urandom_range(0, 4))
					0: reg_val[REG_SRC_SIZE] = 32'hFFFF_FFFF;
					1: reg_val[REG_SRC_SIZE] = $urandom();
					4: reg_val[REG_SRC_SIZE] = $urandom_range(0, 1 << 20);
					default: reg_val[REG_SRC_SIZE] = $urandom_range(0, 20000);
				endcase
				reg_val[REG_LIN_SRC] = $urandom_range(0, 1);
			end
			for (int i = 0; i < 8; i++) begin
				case (i)
					REG_BPP, REG_ALIGN:        w = 5;
					REG_WIDTH, REG_HEIGHT:     w = 15;
					REG_BH_LOG2, REG_BD_LOG2:  w = 3;
					REG_SRC_SIZE:              w = 32;
					default:                   w = 1;
				endcase
				// junk above the field width must be dropped
				noise = ($urandom_range(0, 3) == 0) ? ($urandom() << w) : '0;
				if (w == 32)
					noise = '0;
				write_reg(i[CFG_IDX_W-1:0], reg_val[i] | noise);
			end
			if ($urandom_range(0, 1))
				write_reg(REG_SPARE_FIRST + 4'($urandom_range(0, 7)), $urandom());
			cfg_valid <= 1'b0;

			sent_in_phase = 0;
			while (sent_in_phase < TEXELS_PER_PHASE) begin
				if (phase == 3 && sent_in_phase >= 10 && !held) begin
					held = 1'b1;
					stall_hold = 1'b1;
				end
				if (phase == 5 && sent_in_phase >= 25 && !paused) begin
					paused = 1'b1;
					s_tvalid <= 1'b0;
					do @(negedge clk); while (expected_offsets.size() != 0);
				end
				if ($urandom_range(0, 9) < 8) begin
					// raster run along one line
					lim_w = (shd_width == 0 || shd_width > 16384 || $urandom_range(0, 9) == 0)
						? 16384 : int'(shd_width);
					lim_h = (shd_height == 0 || shd_height > 16384 || $urandom_range(0, 9) == 0)
						? 16384 : int'(shd_height);
					ln = $urandom_range(0, lim_h - 1);
					sl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 3);
					col = $urandom_range(0, lim_w - 1);
					len = $urandom_range(1, 16);
					for (int k = 0; k < len; k++) begin
						send_texel(run_texel(col + k, ln, sl), 1'b0, '0);
						sent_in_phase++;
					end
				end else begin
					send_texel(run_texel($urandom_range(0, 16383), $urandom_range(0, 16383),
						$urandom_range(0, 2047)), 1'b0, '0);
					sent_in_phase++;
				end
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (expected_offsets.size() != 0);
		repeat (16) @(negedge clk);
		$display("Summary: %0d texels, %0d results checked, %0d register writes, %0d phases",
			texels_sent, results_checked, reg_writes, NUM_PHASES);
		$display("Summary: %0d skipped texels, %0d format errors, %0d mismatches",
			skipped_seen, fmt_err_seen, mismatches);
		if (mismatches == 0 && expected_offsets.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
